// ----- hw/rtl/sgg_pkg.sv -----
// Shared types and constants of the sparse GF(2) Gram matrix-vector product block.
package sgg_pkg;

	localparam int WORD_W  = 64;
	localparam int WORD_LSB = 6;
	localparam int IDX_W   = 12;
	localparam int CNT_W   = 13;
	localparam int WIDX_W  = 6;
	localparam int OP_W    = 2;

	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 72;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_ADD_NZ    = 2'd0;
	localparam op_t OP_LOAD_WORD = 2'd1;
	localparam op_t OP_COMPUTE   = 2'd2;
	localparam op_t OP_CLEAR     = 2'd3;

	typedef logic cfg_idx_t;

	localparam cfg_idx_t CFG_ROW_COUNT = 1'b0;
	localparam cfg_idx_t CFG_COL_COUNT = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;

endpackage

// ----- hw/rtl/sgg_ram.sv -----
// Simple dual-port synchronous RAM with one write port and a registered read port.
module sgg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- hw/rtl/sgg_vec_ram.sv -----
// Bit-vector RAM of 64-bit words with per-word valid bits, a bulk clear and write forwarding.
module sgg_vec_ram #(
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       clear,
	input  logic                                       wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [sgg_pkg::WORD_W-1:0]                 wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [sgg_pkg::WORD_W-1:0]                 rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [sgg_pkg::WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]           vld_q;
	logic [sgg_pkg::WORD_W-1:0] rd_q;
	logic                       rd_vld_q;
	logic [AW-1:0]              rd_addr_q;
	logic                       wr_en_q;
	logic [AW-1:0]              wr_addr_q;
	logic [sgg_pkg::WORD_W-1:0] wr_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q      <= mem[rd_addr];
		rd_addr_q <= rd_addr;
		wr_addr_q <= wr_addr;
		wr_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			wr_en_q  <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (clear) begin
				vld_q   <= '0;
				wr_en_q <= 1'b0;
			end else begin
				wr_en_q <= wr_en;
				if (wr_en) begin
					vld_q[wr_addr] <= 1'b1;
				end
			end
		end
	end

	// A write in the cycle of the read is not yet in the RAM output, so it is taken from the
	// write register instead. Words not written since the last clear read as zero.
	assign rd_data = (wr_en_q && (wr_addr_q == rd_addr_q)) ? wr_data_q :
	                 (rd_vld_q ? rd_q : '0);

endmodule

// ----- hw/rtl/sparse_gf2_gram_matvec.sv -----
// Top level: sparse GF(2) product y = A (A^T x) over a stored list of nonzeros.
// Add-nonzero, load-word and clear requests are accepted every cycle while the block is idle.
// A compute request walks the stored nonzeros once per pass, for two passes, through the single
// read port of the nonzero store, then reads, loads and presents each output word in turn and
// holds it until it is taken. No request is accepted from a compute until its last word is taken.
// Reset clears the nonzero count and the drop flag and sets both counts to 4096; no clearing pass.
module sparse_gf2_gram_matvec #(
	parameter int MAX_ROWS     = 4096,
	parameter int MAX_COLS     = 4096,
	parameter int MAX_NONZEROS = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [sgg_pkg::CNT_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// row [11:0], col [23:12], word_index [29:24], in_word [93:30], zero [95:94]
	input  logic [sgg_pkg::S_TDATA_W-1:0]   s_tdata,
	// op [1:0]
	input  logic [sgg_pkg::OP_W-1:0]        s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_index [5:0], out_word [69:6], zero [71:70]
	output logic [sgg_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                            m_tlast,
	// dropped [0]
	output logic                            m_tuser
);

	localparam int RW        = $clog2(MAX_ROWS);
	localparam int CW        = $clog2(MAX_COLS);
	localparam int NZ_W      = RW + CW;
	localparam int ROW_WORDS = (MAX_ROWS + sgg_pkg::WORD_W - 1) / sgg_pkg::WORD_W;
	localparam int COL_WORDS = (MAX_COLS + sgg_pkg::WORD_W - 1) / sgg_pkg::WORD_W;
	localparam int RWA       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
	localparam int CWA       = (COL_WORDS > 1) ? $clog2(COL_WORDS) : 1;
	localparam int NAW       = $clog2(MAX_NONZEROS);
	localparam int NCW       = $clog2(MAX_NONZEROS + 1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_PASS1   = 3'd1;
	localparam logic [2:0] ST_PASS2   = 3'd2;
	localparam logic [2:0] ST_EMIT_RD = 3'd3;
	localparam logic [2:0] ST_EMIT_LD = 3'd4;
	localparam logic [2:0] ST_EMIT_OUT = 3'd5;

	logic [2:0]                     state_q;
	logic [sgg_pkg::CNT_W-1:0]      rows_q;
	logic [sgg_pkg::CNT_W-1:0]      cols_q;
	logic [NCW-1:0]                 nz_count_q;
	logic                           drop_q;
	logic [NCW-1:0]                 k_q;
	logic [sgg_pkg::WIDX_W-1:0]     ei_q;

	logic                           m_valid_q;
	logic [sgg_pkg::WIDX_W-1:0]     m_index_q;
	logic [sgg_pkg::WORD_W-1:0]     m_word_q;
	logic                           m_last_q;
	logic                           m_drop_q;

	logic                           v_s1;
	logic                           v_s2;
	logic                           inr_s2;
	logic [sgg_pkg::WORD_LSB-1:0]   rlo_s2;
	logic [sgg_pkg::WORD_LSB-1:0]   clo_s2;
	logic [RWA-1:0]                 rwa_s2;
	logic [CWA-1:0]                 cwa_s2;

	logic [sgg_pkg::CNT_W-1:0]      rows_use;
	logic [sgg_pkg::CNT_W-1:0]      cols_use;
	logic [sgg_pkg::CNT_W-1:0]      rows_m1;
	logic [sgg_pkg::WIDX_W-1:0]     last_idx;
	logic [sgg_pkg::IDX_W-1:0]      in_row;
	logic [sgg_pkg::IDX_W-1:0]      in_col;
	logic [sgg_pkg::WIDX_W-1:0]     in_widx;
	logic [sgg_pkg::WORD_W-1:0]     in_word;
	logic                           accept;
	logic                           nz_bad;
	logic                           nz_wr_en;
	logic                           x_wr_en;
	logic                           start;
	logic                           in_pass;
	logic                           issue;
	logic                           pass_done;

	logic [NZ_W-1:0]                nz_rd;
	logic [sgg_pkg::IDX_W-1:0]      r_s1;
	logic [sgg_pkg::IDX_W-1:0]      c_s1;
	logic                           inr_s1;
	logic [sgg_pkg::WORD_W-1:0]     x_rd;
	logic [sgg_pkg::WORD_W-1:0]     half_rd;
	logic [sgg_pkg::WORD_W-1:0]     prod_rd;
	logic                           half_bit;
	logic                           prod_bit;
	logic                           half_wr_en;
	logic                           prod_wr_en;
	logic [sgg_pkg::WORD_W-1:0]     half_wr_data;
	logic [sgg_pkg::WORD_W-1:0]     prod_wr_data;
	logic [RWA-1:0]                 prod_rd_addr;

	always_comb begin
		rows_use = (rows_q > sgg_pkg::CNT_W'(MAX_ROWS)) ? sgg_pkg::CNT_W'(MAX_ROWS) : rows_q;
		cols_use = (cols_q > sgg_pkg::CNT_W'(MAX_COLS)) ? sgg_pkg::CNT_W'(MAX_COLS) : cols_q;
		rows_m1  = rows_use - sgg_pkg::CNT_W'(1);
		last_idx = (rows_use == '0) ? '0 : rows_m1[sgg_pkg::IDX_W-1:sgg_pkg::WORD_LSB];
	end

	assign in_row  = s_tdata[11:0];
	assign in_col  = s_tdata[23:12];
	assign in_widx = s_tdata[29:24];
	assign in_word = s_tdata[93:30];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	assign nz_bad   = ({1'b0, in_row} >= rows_use) || ({1'b0, in_col} >= cols_use) ||
	                  (nz_count_q == NCW'(MAX_NONZEROS));
	assign nz_wr_en = accept && (s_tuser == sgg_pkg::OP_ADD_NZ) && !nz_bad;
	assign x_wr_en  = accept && (s_tuser == sgg_pkg::OP_LOAD_WORD) &&
	                  ({1'b0, in_widx} < (sgg_pkg::WIDX_W + 1)'(ROW_WORDS));
	assign start    = accept && (s_tuser == sgg_pkg::OP_COMPUTE);

	assign in_pass   = (state_q == ST_PASS1) || (state_q == ST_PASS2);
	assign issue     = in_pass && (k_q != nz_count_q);
	assign pass_done = in_pass && (k_q == nz_count_q) && !v_s1 && !v_s2;

	// First stage: the nonzero read in the previous cycle selects the vector words.
	always_comb begin
		r_s1   = sgg_pkg::IDX_W'(nz_rd[NZ_W-1:CW]);
		c_s1   = sgg_pkg::IDX_W'(nz_rd[CW-1:0]);
		inr_s1 = ({1'b0, r_s1} < rows_use) && ({1'b0, c_s1} < cols_use);
		prod_rd_addr = (state_q == ST_EMIT_RD) ? ei_q[RWA-1:0] :
		               r_s1[sgg_pkg::WORD_LSB +: RWA];
	end

	// Second stage: flip one bit of the half vector (first pass) or product vector (second).
	always_comb begin
		half_bit     = inr_s2 && x_rd[rlo_s2];
		prod_bit     = inr_s2 && half_rd[clo_s2];
		half_wr_en   = v_s2 && (state_q == ST_PASS1);
		prod_wr_en   = v_s2 && (state_q == ST_PASS2);
		half_wr_data = half_rd ^ (sgg_pkg::WORD_W'(half_bit) << clo_s2);
		prod_wr_data = prod_rd ^ (sgg_pkg::WORD_W'(prod_bit) << rlo_s2);
	end

	sgg_ram #(
		.WIDTH(NZ_W),
		.DEPTH(MAX_NONZEROS)
	) u_nz_store (
		.clk     (clk),
		.wr_en   (nz_wr_en),
		.wr_addr (nz_count_q[NAW-1:0]),
		.wr_data ({in_row[RW-1:0], in_col[CW-1:0]}),
		.rd_addr (k_q[NAW-1:0]),
		.rd_data (nz_rd)
	);

	sgg_ram #(
		.WIDTH(sgg_pkg::WORD_W),
		.DEPTH(ROW_WORDS)
	) u_x_ram (
		.clk     (clk),
		.wr_en   (x_wr_en),
		.wr_addr (in_widx[RWA-1:0]),
		.wr_data (in_word),
		.rd_addr (r_s1[sgg_pkg::WORD_LSB +: RWA]),
		.rd_data (x_rd)
	);

	sgg_vec_ram #(
		.DEPTH(COL_WORDS)
	) u_half_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (start),
		.wr_en   (half_wr_en),
		.wr_addr (cwa_s2),
		.wr_data (half_wr_data),
		.rd_addr (c_s1[sgg_pkg::WORD_LSB +: CWA]),
		.rd_data (half_rd)
	);

	sgg_vec_ram #(
		.DEPTH(ROW_WORDS)
	) u_prod_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (start),
		.wr_en   (prod_wr_en),
		.wr_addr (rwa_s2),
		.wr_data (prod_wr_data),
		.rd_addr (prod_rd_addr),
		.rd_data (prod_rd)
	);

	always_ff @(posedge clk) begin
		inr_s2 <= inr_s1;
		rlo_s2 <= r_s1[sgg_pkg::WORD_LSB-1:0];
		clo_s2 <= c_s1[sgg_pkg::WORD_LSB-1:0];
		rwa_s2 <= r_s1[sgg_pkg::WORD_LSB +: RWA];
		cwa_s2 <= c_s1[sgg_pkg::WORD_LSB +: CWA];
		if (state_q == ST_EMIT_LD) begin
			m_index_q <= ei_q;
			m_word_q  <= prod_rd;
			m_last_q  <= (ei_q == last_idx);
			m_drop_q  <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= sgg_pkg::COUNT_RESET;
			cols_q     <= sgg_pkg::COUNT_RESET;
			state_q    <= ST_IDLE;
			nz_count_q <= '0;
			drop_q     <= 1'b0;
			k_q        <= '0;
			ei_q       <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sgg_pkg::CFG_ROW_COUNT: rows_q <= cfg_data;
					sgg_pkg::CFG_COL_COUNT: cols_q <= cfg_data;
					default: ;
				endcase
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) begin
				k_q <= k_q + NCW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							sgg_pkg::OP_ADD_NZ: begin
								if (nz_bad) begin
									drop_q <= 1'b1;
								end else begin
									nz_count_q <= nz_count_q + NCW'(1);
								end
							end
							sgg_pkg::OP_CLEAR: begin
								nz_count_q <= '0;
								drop_q     <= 1'b0;
							end
							sgg_pkg::OP_COMPUTE: begin
								k_q     <= '0;
								state_q <= ST_PASS1;
							end
							default: ;
						endcase
					end
				end
				ST_PASS1: begin
					if (pass_done) begin
						k_q     <= '0;
						state_q <= ST_PASS2;
					end
				end
				ST_PASS2: begin
					if (pass_done) begin
						ei_q    <= '0;
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					m_valid_q <= 1'b1;
					state_q   <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (m_tready) begin
						m_valid_q <= 1'b0;
						if (m_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							ei_q    <= ei_q + sgg_pkg::WIDX_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_word_q, m_index_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_drop_q;

endmodule
